// ===== sv/wrf_pkg.sv =====
// Shared types and constants for the waveform ROI region finder.
// Used by wrf_out_fifo and waveform_roi_region_finder_core; no dependencies.
package wrf_pkg;

  // Waveform geometry
  localparam int unsigned WAVEFORM_LENGTH = 2000;
  localparam int unsigned HALF_WINDOW     = 100;
  localparam int unsigned TICK_W          = 11;

  // Configuration register map (register index from paddr[2])
  localparam logic REG_THRESHOLD = 1'b0;

  // Output queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef logic [TICK_W-1:0] tick_t;

  // One region record
  typedef struct packed {
    tick_t region_start;
    tick_t region_end;
    logic  region_valid;
    logic  waveform_done;
  } result_t;

  // Records produced by one accepted sample, packed from d0 up
  typedef struct packed {
    logic [1:0] n;
    result_t    d0;
    result_t    d1;
  } push_t;

endpackage

// ===== sv/wrf_out_fifo.sv =====
// Small output queue for region records; takes up to two records per cycle.
// Depends on wrf_pkg for result_t, push_t and the queue geometry.
module wrf_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  wrf_pkg::push_t    push,
  output logic              room,
  output logic              out_valid,
  output wrf_pkg::result_t  out_data,
  input  logic              out_ready
);

  wrf_pkg::result_t mem [wrf_pkg::FIFO_DEPTH];
  logic [wrf_pkg::FIFO_AW-1:0] wr_ptr;
  logic [wrf_pkg::FIFO_AW-1:0] rd_ptr;
  logic [wrf_pkg::FIFO_AW:0]   count;
  logic [wrf_pkg::FIFO_AW:0]   count_next;
  logic                        pop;

  // Room for a full two-record burst
  assign room      = count <= 3'(wrf_pkg::FIFO_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next = count + {1'b0, push.n} - {{wrf_pkg::FIFO_AW{1'b0}}, pop};
  end

  // Store records
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.d0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.d1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

endmodule

// ===== sv/waveform_roi_region_finder_core.sv =====
// Waveform ROI region finder: thresholds samples, merges padded spans into regions.
// Records are written into the output queue (wrf_out_fifo) as the sample beat is taken and offered from there.
// Throughput: one sample per cycle while the four-entry output queue has room for two
//   records, absorbing the rare two-record sample (region closed by distance plus final record).
// Reset (rst, synchronous): tick 0, no region open, threshold 0, queue empty.
// Depends on wrf_pkg and wrf_out_fifo.
module waveform_roi_region_finder_core (
  input  logic        clk,
  input  logic        rst,
  // Sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample (signed)
  input  logic        s_tlast,   // last_sample
  // Region stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [10:0] region_start, [21:11] region_end, [23:22] zero
  output logic        m_tuser,   // [0] region_valid
  output logic        m_tlast,   // waveform_done
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [11:0] CloseGap  = 12'(wrf_pkg::HALF_WINDOW + 1);
  localparam logic [11:0] HalfWin12 = 12'(wrf_pkg::HALF_WINDOW);
  localparam logic [11:0] LastTick  = 12'(wrf_pkg::WAVEFORM_LENGTH - 1);

  logic signed [15:0] threshold;
  wrf_pkg::tick_t     tick_index;
  logic               region_open;
  wrf_pkg::tick_t     open_start;
  wrf_pkg::tick_t     open_end;

  wrf_pkg::tick_t     tick_index_next;
  logic               region_open_next;
  wrf_pkg::tick_t     open_start_next;
  wrf_pkg::tick_t     open_end_next;

  logic               accept;
  logic               hit;
  logic               dist_close;
  logic               open_kept;
  logic [11:0]        span_st;
  logic [11:0]        span_en;
  logic               merge;
  logic               open_after;
  wrf_pkg::tick_t     start_after;
  wrf_pkg::tick_t     end_after;
  wrf_pkg::tick_t     final_end;
  wrf_pkg::result_t   close_rec;
  wrf_pkg::result_t   last_rec;
  wrf_pkg::push_t     push;
  logic               room;
  wrf_pkg::result_t   out_rec;

  // Configuration port: always ready, one register
  assign pready = 1'b1;
  assign prdata = {{16{threshold[15]}}, threshold};

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == wrf_pkg::REG_THRESHOLD) begin
      threshold <= pwdata[15:0];
    end
  end

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  // Per-sample region tracking
  always_comb begin
    hit = $signed(s_tdata) > threshold;

    // Close the open region once no later span can reach it
    dist_close = region_open && ({1'b0, tick_index} > ({1'b0, open_end} + CloseGap))
                 && (!s_tlast || hit);
    open_kept  = region_open && !dist_close;

    // Padded span around this tick, clipped to the waveform
    span_st = ({1'b0, tick_index} >= HalfWin12) ? {1'b0, tick_index} - HalfWin12 : 12'd0;
    span_en = {1'b0, tick_index} + HalfWin12 - 12'd1;
    if (span_en > LastTick) begin
      span_en = LastTick;
    end

    merge = open_kept && (span_st <= ({1'b0, open_end} + 12'd1));

    open_after  = open_kept;
    start_after = open_start;
    end_after   = open_end;
    if (hit) begin
      open_after = 1'b1;
      if (merge) begin
        if (span_en[10:0] > open_end) begin
          end_after = span_en[10:0];
        end
      end else begin
        start_after = span_st[10:0];
        end_after   = span_en[10:0];
      end
    end

    // Early end clips the open region to the current tick
    final_end = (end_after > tick_index) ? tick_index : end_after;

    close_rec.region_start  = open_start;
    close_rec.region_end    = open_end;
    close_rec.region_valid  = 1'b1;
    close_rec.waveform_done = 1'b0;

    last_rec.region_start  = open_after ? start_after : '0;
    last_rec.region_end    = open_after ? final_end : '0;
    last_rec.region_valid  = open_after;
    last_rec.waveform_done = 1'b1;

    // Pack records from slot 0 up
    push.n  = 2'd0;
    push.d0 = last_rec;
    push.d1 = last_rec;
    if (accept) begin
      if (dist_close) begin
        push.d0 = close_rec;
        push.n  = s_tlast ? 2'd2 : 2'd1;
      end else begin
        push.n  = s_tlast ? 2'd1 : 2'd0;
      end
    end

    // Next state
    if (s_tlast) begin
      tick_index_next  = '0;
      region_open_next = 1'b0;
      open_start_next  = '0;
      open_end_next    = '0;
    end else begin
      tick_index_next  = ({1'b0, tick_index} < LastTick) ? tick_index + 11'd1 : tick_index;
      region_open_next = open_after;
      open_start_next  = start_after;
      open_end_next    = end_after;
    end
  end

  // Hold state between beats
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_index  <= '0;
      region_open <= 1'b0;
      open_start  <= '0;
      open_end    <= '0;
    end else if (accept) begin
      tick_index  <= tick_index_next;
      region_open <= region_open_next;
      open_start  <= open_start_next;
      open_end    <= open_end_next;
    end
  end

  // Result queue
  wrf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_data  (out_rec),
    .out_ready (m_tready)
  );

  assign m_tdata = {2'b00, out_rec.region_end, out_rec.region_start};
  assign m_tuser = out_rec.region_valid;
  assign m_tlast = out_rec.waveform_done;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for waveform_roi_region_finder_core: streams waveforms, predicts
// region records per accepted sample beat and checks every record beat in order.
// Depends on wrf_pkg and the core RTL only.
module tb;

  typedef struct {
    logic [15:0] value;
    logic        is_last;
  } sample_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;     // [15:0] sample (signed)
  logic        s_tlast = 1'b0;   // last_sample
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [10:0] region_start, [21:11] region_end, [23:22] zero
  logic        m_tuser;          // [0] region_valid
  logic        m_tlast;          // waveform_done
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  waveform_roi_region_finder_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus and expectation stores
  sample_beat_t      samples_pending[$];
  wrf_pkg::result_t  regions_due[$];
  sample_beat_t      tx_beat;

  // Run limit
  initial begin
    #2_000_000;
    $display("** waveform_roi_region_finder_core: FAILED **");
    $display("run limit reached: %0d records still expected", regions_due.size());
    $finish;
  end

  // Predictor state
  logic signed [15:0] thr_reg = '0;
  int unsigned        wf_tick = 0;
  bit                 span_open = 0;
  int unsigned        span_start = 0;
  int unsigned        span_end = 0;

  // Flow control knobs and bookkeeping
  bit tx_idle_on = 1;
  bit rx_idle_on = 1;
  int tx_gap = 0;
  int rx_stall = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int beats_queued = 0;
  int beats_taken = 0;
  int waveforms_done = 0;
  int double_steps = 0;
  int settings_used = 1;
  int records_seen = 0;
  int regions_seen = 0;
  int empties_seen = 0;
  int errors = 0;

  function automatic int pick_idle_len(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Draw a sample above or at/below the current threshold, favoring the edges
  function automatic logic [15:0] pick_sample(bit want_hit);
    int thr, lo, hi, v;
    thr = thr_reg;
    if ($urandom_range(99) < 4) return 16'($urandom);
    if (want_hit && thr < 32767) begin
      lo = thr + 1;
      hi = 32767;
    end else begin
      lo = -32768;
      hi = thr;
    end
    case ($urandom_range(3))
      0: v = lo;
      1: v = hi;
      default: v = lo + int'($urandom_range(hi - lo));
    endcase
    return 16'(v);
  endfunction

  task automatic add_beat(input logic [15:0] value, input logic is_last);
    sample_beat_t b;
    b.value = value;
    b.is_last = is_last;
    samples_pending = {samples_pending, b};
    beats_queued++;
  endtask

  task automatic add_waveform(input int len, input int hit_pm);
    for (int t = 0; t < len; t++)
      add_beat(pick_sample($urandom_range(999) < hit_pm), t == len - 1);
  endtask

  // Two hits roughly a closing distance apart, second one usually on the last tick
  task automatic add_split_waveform();
    int first, second, tail;
    first = $urandom_range(60);
    second = first + $urandom_range(320, 195);
    tail = ($urandom_range(3) != 0) ? 0 : $urandom_range(120, 1);
    for (int t = 0; t <= second + tail; t++)
      add_beat(pick_sample(t == first || (t == second && $urandom_range(9) < 8) ||
                           (t > second && $urandom_range(99) < 5)), t == second + tail);
  endtask

  // Run past the final tick so the counter saturates, with hits near the end
  task automatic add_long_waveform();
    for (int t = 0; t < wrf_pkg::WAVEFORM_LENGTH + 10; t++)
      add_beat(pick_sample(t == 1950 || t == wrf_pkg::WAVEFORM_LENGTH + 5 ||
                           $urandom_range(999) < 3), t == wrf_pkg::WAVEFORM_LENGTH + 9);
  endtask

  task automatic add_random_waveform();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) add_waveform($urandom_range(30, 1), $urandom_range(500));
    else if (pick < 70) add_waveform($urandom_range(400, 150), $urandom_range(20, 5));
    else if (pick < 85) add_split_waveform();
    else if (pick < 95) add_waveform($urandom_range(200, 40), $urandom_range(300, 50));
    else add_waveform($urandom_range(8, 1), 0);
  endtask

  task automatic expect_region(input int unsigned st, input int unsigned en,
                               input logic valid, input logic done);
    wrf_pkg::result_t r;
    r.region_start = wrf_pkg::tick_t'(st);
    r.region_end = wrf_pkg::tick_t'(en);
    r.region_valid = valid;
    r.waveform_done = done;
    regions_due = {regions_due, r};
  endtask

  // Advance the region state by one sample and queue the records it causes
  task automatic predict_regions(input logic signed [15:0] smp, input logic is_last);
    int unsigned i, st, en;
    int n;
    bit hit;
    i = wf_tick;
    n = 0;
    hit = smp > thr_reg;
    // close a region that no later sample can reach
    if (span_open && i > span_end + 1 + wrf_pkg::HALF_WINDOW && (!is_last || hit)) begin
      expect_region(span_start, span_end, 1'b1, 1'b0);
      n++;
      span_open = 0;
    end
    // mark the padded span, merge when it overlaps or touches
    if (hit) begin
      st = (i >= wrf_pkg::HALF_WINDOW) ? i - wrf_pkg::HALF_WINDOW : 0;
      en = i + wrf_pkg::HALF_WINDOW - 1;
      if (en > wrf_pkg::WAVEFORM_LENGTH - 1) en = wrf_pkg::WAVEFORM_LENGTH - 1;
      if (span_open && st <= span_end + 1) begin
        if (en > span_end) span_end = en;
      end else begin
        span_open = 1;
        span_start = st;
        span_end = en;
      end
    end
    // final record of the waveform, end clipped to the last tick
    if (is_last) begin
      if (span_open) expect_region(span_start, (span_end > i) ? i : span_end, 1'b1, 1'b1);
      else expect_region(0, 0, 1'b0, 1'b1);
      n++;
      wf_tick = 0;
      span_open = 0;
      span_start = 0;
      span_end = 0;
      waveforms_done++;
    end else if (wf_tick < wrf_pkg::WAVEFORM_LENGTH - 1) begin
      wf_tick++;
    end
    if (n == 2) double_steps++;
  endtask

  task automatic check_region(input wrf_pkg::result_t got);
    wrf_pkg::result_t want;
    records_seen++;
    if (got.region_valid) regions_seen++;
    else empties_seen++;
    if (regions_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected record: start=%0d end=%0d valid=%0b done=%0b",
                 got.region_start, got.region_end, got.region_valid, got.waveform_done);
      return;
    end
    want = regions_due.pop_front();
    if (got.region_start !== want.region_start || got.region_end !== want.region_end ||
        got.region_valid !== want.region_valid || got.waveform_done !== want.waveform_done)
    begin
      errors++;
      if (errors <= 10) begin
        $display("record mismatch: expected start=%0d end=%0d valid=%0b done=%0b,",
                 want.region_start, want.region_end, want.region_valid, want.waveform_done);
        $display("                 got start=%0d end=%0d valid=%0b done=%0b",
                 got.region_start, got.region_end, got.region_valid, got.waveform_done);
      end
    end
  endtask

  // Sample driver: hold the beat until taken, then idle or load the next one
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_regions(s_tdata, s_tlast);
        beats_taken++;
        tx_gap = pick_idle_len(tx_idle_on);
      end
      if (s_tvalid && !s_tready) begin
        // beat still offered
      end else if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (samples_pending.size() > 0) begin
        tx_beat = samples_pending.pop_front();
        s_tdata <= tx_beat.value;
        s_tlast <= tx_beat.is_last;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Record monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        check_region(wrf_pkg::result_t'({m_tdata[10:0], m_tdata[21:11], m_tuser, m_tlast}));
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(3) == 0) rx_stall = pick_idle_len(rx_idle_on);
      end
    end
  end

  // Write the threshold register: setup beat, then access beat
  task automatic apb_write(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {wrf_pkg::REG_THRESHOLD, 2'b00};
    pwdata <= {{16{value[15]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thr_reg = value;
    settings_used++;
  endtask

  // Wait until every sample is taken and every record has come back
  task automatic wait_drained();
    while (beats_taken != beats_queued || regions_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int base_beats;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes and the threshold edge at the reset setting
    add_beat(16'h7FFF, 1'b1);
    add_beat(16'h0000, 1'b1);
    add_beat(16'h8000, 1'b1);
    add_beat(16'h0001, 1'b1);
    add_beat(16'hFFFF, 1'b0);
    add_beat(16'h0001, 1'b0);
    add_beat(16'hFFFF, 1'b1);
    add_beat(16'h5555, 1'b0);
    add_beat(16'hAAAA, 1'b0);
    add_beat(16'h0000, 1'b0);
    add_beat(16'h7FFF, 1'b1);
    wait_drained();

    // Lowest threshold: all but the most negative sample hit
    apb_write(16'h8000);
    add_beat(16'h8000, 1'b1);
    add_beat(16'h8001, 1'b1);
    repeat (4) add_random_waveform();
    wait_drained();

    // Highest threshold: nothing can hit, only empty records
    apb_write(16'h7FFF);
    add_beat(16'h7FFF, 1'b1);
    repeat (8) add_waveform($urandom_range(40, 1), 500);
    wait_drained();

    // Receiver holds off while short waveforms pile up behind the output queue
    apb_write(16'h0000);
    tx_idle_on = 0;
    hold_req++;
    repeat (40) add_waveform($urandom_range(2, 1), 500);
    wait_drained();

    // Long waveform running past the last tick
    apb_write(16'h0100);
    tx_idle_on = 1;
    add_long_waveform();
    wait_drained();

    // Random phases, each with its own threshold and idle mix
    base_beats = beats_queued;
    while (beats_queued - base_beats < 1100) begin
      if ($urandom_range(3) == 0) apb_write(16'($urandom));
      else apb_write(16'(int'($urandom_range(4096)) - 2048));
      tx_idle_on = ($urandom_range(3) != 0);
      rx_idle_on = ($urandom_range(3) != 0);
      repeat ($urandom_range(8, 3)) add_random_waveform();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (regions_due.size() != 0) begin
      errors += regions_due.size();
      $display("%0d expected records never arrived", regions_due.size());
    end
    $display("Streamed %0d samples in %0d waveforms under %0d threshold settings,",
             beats_taken, waveforms_done, settings_used);
    $display("%0d steps gave two records; checked %0d records (%0d regions, %0d empty).",
             double_steps, records_seen, regions_seen, empties_seen);
    if (errors == 0) begin
      $display("** waveform_roi_region_finder_core: PASSED **");
    end else begin
      $display("** waveform_roi_region_finder_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wrf_pkg.sv
sv/wrf_out_fifo.sv
sv/waveform_roi_region_finder_core.sv
tb/tb.sv
